>>> src/prime_and_twin_counter_core_assert.svh
// Assertion macros shared by the prime and twin counter modules.
// Depends on nothing; each user supplies its own clock and active-low reset.
`ifndef PRIME_AND_TWIN_COUNTER_CORE_ASSERT_SVH
`define PRIME_AND_TWIN_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptc assertion failed");

`endif

>>> src/ptc_pkg.sv
// Shared types for the prime and twin counter: controller states and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package ptc_pkg;

  localparam int COUNT_WIDTH = 13;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CAND = 6'b000010,
    ST_TEST = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_CHK  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  typedef struct packed {
    logic start;
    logic cand_init;
    logic div_init;
    logic div_step;
    logic next_d;
    logic record;
    logic rec_prime;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic past_end;
    logic le1;
    logic le3;
    logic even;
    logic sq_gt_n;
    logic div_last;
    logic rem_zero;
  } status_t;

endpackage

>>> src/prime_and_twin_counter_core.sv
// Top level of the prime and twin counter: controller plus datapath.
// Depends on ptc_pkg, ptc_ctrl and ptc_datapath.
`timescale 1ns / 1ps

//  Channel  Direction  Ports                                 Transaction
//  in       input      in_valid, in_stall, in_limit          one upper limit N
//  out      output     out_valid, out_stall,                 prime and twin counts
//                      out_prime_count, out_twin_count
//
// Each candidate c from 2 through N + 2 is classified in turn. Values up to 3 and even values
// are recorded straight from the candidate state. An odd candidate is tried against odd trial
// divisors from 3 by a bit-serial remainder (while d * d <= c, up to the smallest factor).
// Start, end check and result load are steps of their own around the candidate loop.
// Reset clears the controller and the result valid flag; payload is not reset. A new limit
// is taken while a result waits, and an output stall holds the block only at a second load.

module prime_and_twin_counter_core #(
  parameter int LIMIT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [LIMIT_WIDTH-1:0]           in_limit,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ptc_pkg::COUNT_WIDTH-1:0]  out_prime_count,
  output logic [ptc_pkg::COUNT_WIDTH-1:0]  out_twin_count
);
  import ptc_pkg::*;

  // Commands from the sequencer and the datapath's comparison results.
  cmd_t    cmd;
  status_t status;

  ptc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd_o    (cmd),
    .status_i (status)
  );

  // The datapath holds the limit, the candidate window, the trial divisor with
  // its running square, the remainder unit and both counts.
  ptc_datapath #(
    .LIMIT_WIDTH(LIMIT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_limit       (in_limit),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_prime_count(out_prime_count),
    .out_twin_count (out_twin_count)
  );

endmodule

>>> src/ptc_ctrl.sv
// Controller state machine of the prime and twin counter.
// Depends on ptc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "prime_and_twin_counter_core_assert.svh"

module ptc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output ptc_pkg::cmd_t     cmd_o,
  input  ptc_pkg::status_t  status_i
);
  import ptc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_o.start = 1'b1;
          state_nxt   = ST_CAND;
        end
      end
      ST_CAND: begin
        priority if (status_i.past_end) begin
          state_nxt = ST_FIN;
        end else if (status_i.le1) begin
          cmd_o.record = 1'b1;
        end else if (status_i.le3) begin
          cmd_o.record    = 1'b1;
          cmd_o.rec_prime = 1'b1;
        end else if (status_i.even) begin
          cmd_o.record = 1'b1;
        end else begin
          cmd_o.cand_init = 1'b1;
          state_nxt       = ST_TEST;
        end
      end
      ST_TEST: begin
        if (status_i.sq_gt_n) begin
          cmd_o.record    = 1'b1;
          cmd_o.rec_prime = 1'b1;
          state_nxt       = ST_CAND;
        end else begin
          cmd_o.div_init = 1'b1;
          state_nxt      = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (status_i.rem_zero) begin
          cmd_o.record = 1'b1;
          state_nxt    = ST_CAND;
        end else begin
          cmd_o.next_d = 1'b1;
          state_nxt    = ST_TEST;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_o.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // The result register is only overwritten once the previous result has left.
  `PTC_ASSERT_NOW(a_load_free, clk, rst_n, cmd_o.load_out, (!out_valid_r || !out_stall))
  // An accepted transaction always starts with candidate classification.
  `PTC_ASSERT_NEXT(a_start_cand, clk, rst_n, (state_r == ST_IDLE) && in_valid,
    state_r == ST_CAND)
  // A candidate is never recorded while its remainder is still being formed.
  `PTC_ASSERT_NOW(a_no_rec_in_div, clk, rst_n, cmd_o.div_step, !cmd_o.record)

endmodule

>>> src/ptc_datapath.sv
// Datapath of the prime and twin counter: candidate and divisor registers,
// a bit-serial remainder unit and the two counters. Depends on ptc_pkg and
// the assertion macro header.
`timescale 1ns / 1ps
`include "prime_and_twin_counter_core_assert.svh"

module ptc_datapath #(
  parameter int LIMIT_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [LIMIT_WIDTH-1:0]           in_limit,
  input  ptc_pkg::cmd_t                    cmd_i,
  output ptc_pkg::status_t                 status_o,
  output logic [ptc_pkg::COUNT_WIDTH-1:0]  out_prime_count,
  output logic [ptc_pkg::COUNT_WIDTH-1:0]  out_twin_count
);
  import ptc_pkg::*;

  // Candidates run up to limit + 2, one bit wider than the limit.
  localparam int CW  = LIMIT_WIDTH + 1;
  localparam int DW  = (CW + 1) / 2 + 2;
  localparam int SQW = CW + 1;
  localparam int BCW = $clog2(CW);

  logic [CW-1:0]          limit_r, limit_nxt;
  logic [CW-1:0]          end_r, end_nxt;
  logic [CW-1:0]          c_r, c_nxt;
  logic [DW-1:0]          d_r, d_nxt;
  logic [SQW-1:0]         sq_r, sq_nxt;
  logic [CW-1:0]          sh_r, sh_nxt;
  logic [DW:0]            rem_r, rem_nxt;
  logic [BCW-1:0]         bitcnt_r, bitcnt_nxt;
  logic                   w1_r, w1_nxt;
  logic                   w2_r, w2_nxt;
  logic [COUNT_WIDTH-1:0] pcnt_r, pcnt_nxt;
  logic [COUNT_WIDTH-1:0] tcnt_r, tcnt_nxt;
  logic [COUNT_WIDTH-1:0] outp_r, outp_nxt;
  logic [COUNT_WIDTH-1:0] outt_r, outt_nxt;
  logic [DW:0]            rem_sh;

  assign rem_sh = {rem_r[DW-1:0], sh_r[CW-1]};

  always_comb begin
    limit_nxt  = limit_r;
    end_nxt    = end_r;
    c_nxt      = c_r;
    d_nxt      = d_r;
    sq_nxt     = sq_r;
    sh_nxt     = sh_r;
    rem_nxt    = rem_r;
    bitcnt_nxt = bitcnt_r;
    w1_nxt     = w1_r;
    w2_nxt     = w2_r;
    pcnt_nxt   = pcnt_r;
    tcnt_nxt   = tcnt_r;
    outp_nxt   = outp_r;
    outt_nxt   = outt_r;

    if (cmd_i.start) begin
      limit_nxt = {1'b0, in_limit};
      end_nxt   = {1'b0, in_limit} + CW'(2);
      c_nxt     = CW'(2);
      w1_nxt    = 1'b0;
      w2_nxt    = 1'b0;
      pcnt_nxt  = '0;
      tcnt_nxt  = '0;
    end
    if (cmd_i.cand_init) begin
      d_nxt  = DW'(3);
      sq_nxt = SQW'(9);
    end
    if (cmd_i.div_init) begin
      sh_nxt     = c_r;
      rem_nxt    = '0;
      bitcnt_nxt = '0;
    end
    if (cmd_i.div_step) begin
      // One restoring step: bring in the next dividend bit, subtract if it fits.
      sh_nxt     = {sh_r[CW-2:0], 1'b0};
      bitcnt_nxt = bitcnt_r + BCW'(1);
      if (rem_sh >= {1'b0, d_r}) begin
        rem_nxt = rem_sh - {1'b0, d_r};
      end else begin
        rem_nxt = rem_sh;
      end
    end
    if (cmd_i.next_d) begin
      // (d + 2)^2 = d^2 + 4d + 4
      d_nxt  = d_r + DW'(2);
      sq_nxt = sq_r + SQW'({d_r, 2'b00}) + SQW'(4);
    end
    if (cmd_i.record) begin
      if (cmd_i.rec_prime && (c_r <= limit_r)) begin
        pcnt_nxt = pcnt_r + COUNT_WIDTH'(1);
      end
      if (cmd_i.rec_prime && w2_r) begin
        tcnt_nxt = tcnt_r + COUNT_WIDTH'(1);
      end
      w2_nxt = w1_r;
      w1_nxt = cmd_i.rec_prime;
      c_nxt  = c_r + CW'(1);
    end
    if (cmd_i.load_out) begin
      outp_nxt = pcnt_r;
      outt_nxt = tcnt_r;
    end
  end

  always_ff @(posedge clk) begin
    limit_r  <= limit_nxt;
    end_r    <= end_nxt;
    c_r      <= c_nxt;
    d_r      <= d_nxt;
    sq_r     <= sq_nxt;
    sh_r     <= sh_nxt;
    rem_r    <= rem_nxt;
    bitcnt_r <= bitcnt_nxt;
    w1_r     <= w1_nxt;
    w2_r     <= w2_nxt;
    pcnt_r   <= pcnt_nxt;
    tcnt_r   <= tcnt_nxt;
    outp_r   <= outp_nxt;
    outt_r   <= outt_nxt;
  end

  always_comb begin
    status_o.past_end = (c_r > end_r);
    status_o.le1      = (c_r < CW'(2));
    status_o.le3      = (c_r < CW'(4));
    status_o.even     = ~c_r[0];
    status_o.sq_gt_n  = (sq_r > {1'b0, c_r});
    status_o.div_last = (bitcnt_r == BCW'(CW - 1));
    status_o.rem_zero = (rem_r == '0);
  end

  assign out_prime_count = outp_r;
  assign out_twin_count  = outt_r;

  // A restoring step always leaves a partial remainder below the divisor.
  `PTC_ASSERT_NEXT(a_rem_below_d, clk, rst_n, cmd_i.div_step, rem_r < {1'b0, d_r})
  // Trial divisors stay odd.
  `PTC_ASSERT_NOW(a_d_odd, clk, rst_n, cmd_i.div_init, d_r[0])
  // The primality window shifts in the recorded verdict.
  `PTC_ASSERT_NEXT(a_window, clk, rst_n, cmd_i.record, w1_r == $past(cmd_i.rec_prime))

endmodule
